// ----- hw/rtl/tkvp_pkg.sv -----
// ----------------------------------------------------------------------------
// tkvp_pkg
// Shared types, codes and character tables for the texture key/value
// record parser.
// ----------------------------------------------------------------------------
package tkvp_pkg;

  // largest region the parser accepts, in bytes
  localparam logic [20:0] MAX_REGION_BYTES = 21'd524288;

  // configuration register indexes
  localparam logic CFG_SWAP_SIZE_BYTES = 1'b0;
  localparam logic CFG_REGION_BYTES    = 1'b1;

  // byte role tags
  localparam logic [2:0] ROLE_SIZE      = 3'd0;
  localparam logic [2:0] ROLE_KEY       = 3'd1;
  localparam logic [2:0] ROLE_KEY_END   = 3'd2;
  localparam logic [2:0] ROLE_VALUE     = 3'd3;
  localparam logic [2:0] ROLE_VALUE_END = 3'd4;
  localparam logic [2:0] ROLE_PAD       = 3'd5;
  localparam logic [2:0] ROLE_IGNORED   = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_OVERRUN       = 3'd1;
  localparam logic [2:0] ERR_KEY_NUL       = 3'd2;
  localparam logic [2:0] ERR_VALUE_NUL     = 3'd3;
  localparam logic [2:0] ERR_SIZE_TRUNC    = 3'd4;

  // length of the orientation key and of the compared value prefix
  localparam logic [3:0] ORIENT_KEY_LEN = 4'd14;
  localparam logic [2:0] ORIENT_VAL_LEN = 3'd7;

  // one result beat
  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] byte_role;
    logic       record_ok;
    logic [2:0] error_code;
    logic [1:0] flip_bits;
    logic       orientation_seen;
  } tkvp_result_t;

  // characters of "KTXorientation"
  function automatic logic [7:0] orient_key_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = "K";
      4'd1:    c = "T";
      4'd2:    c = "X";
      4'd3:    c = "o";
      4'd4:    c = "r";
      4'd5:    c = "i";
      4'd6:    c = "e";
      4'd7:    c = "n";
      4'd8:    c = "t";
      4'd9:    c = "a";
      4'd10:   c = "t";
      4'd11:   c = "i";
      4'd12:   c = "o";
      4'd13:   c = "n";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // characters of the four orientation values, "S=r,T=d" and friends
  function automatic logic [7:0] orient_val_char(input logic [1:0] idx,
                                                 input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = "S";
      3'd1:    c = "=";
      3'd2:    c = idx[1] ? "l" : "r";
      3'd3:    c = ",";
      3'd4:    c = "T";
      3'd5:    c = "=";
      3'd6:    c = idx[0] ? "u" : "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/tkvp_core.sv -----
// ----------------------------------------------------------------------------
// tkvp_core
// Parser state, configuration registers and the per-byte step logic.
// Produces one result beat for every accepted input beat.
// ----------------------------------------------------------------------------
module tkvp_core
  import tkvp_pkg::*;
#(
  parameter logic [20:0] MAX_REGION = MAX_REGION_BYTES
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [19:0]  cfg_data,
  input  logic         in_fire,
  input  logic [7:0]   data_byte,
  input  logic         region_start,
  output tkvp_result_t result
);

  // parse phase codes
  localparam logic [1:0] PH_SIZE  = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_PAD   = 2'd3;

  typedef struct packed {
    logic [1:0]  phase;
    logic [23:0] size_accum;
    logic [1:0]  size_cnt;
    logic [19:0] record_left;
    logic [1:0]  pad_left;
    logic [19:0] region_used;
    logic [3:0]  key_pos;
    logic        key_is_orient;
    logic [2:0]  value_pos;
    logic [3:0]  value_mask;
    logic        orient_found;
    logic [1:0]  flip_state;
    logic        stopped;
  } core_state_t;

  localparam core_state_t STATE_CLEAR = '{
    phase: PH_SIZE, size_accum: 24'd0, size_cnt: 2'd0, record_left: 20'd0,
    pad_left: 2'd0, region_used: 20'd0, key_pos: 4'd0, key_is_orient: 1'b1,
    value_pos: 3'd0, value_mask: 4'hF, orient_found: 1'b0, flip_state: 2'd1,
    stopped: 1'b0};

  logic        swap_size_bytes;
  logic [19:0] region_bytes;
  core_state_t st;
  core_state_t cur;
  core_state_t st_next;

  logic        active;
  logic [19:0] used_inc;
  logic [19:0] left_dec;
  logic [31:0] size_word;
  logic [32:0] size_end;
  logic [3:0]  mask_upd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_size_bytes <= 1'b0;
      region_bytes    <= 20'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SWAP_SIZE_BYTES: swap_size_bytes <= cfg_data[0];
        CFG_REGION_BYTES:    region_bytes    <= cfg_data;
        default:             region_bytes    <= region_bytes;
      endcase
    end
  end

  // region start clears the parser before the byte is stepped
  assign cur      = region_start ? STATE_CLEAR : st;
  assign used_inc = cur.region_used + 20'd1;
  assign left_dec = cur.record_left - 20'd1;
  assign active   = (region_bytes != 20'd0) &&
                    ({1'b0, region_bytes} <= MAX_REGION) &&
                    !cur.stopped && (cur.region_used < region_bytes);

  // assembled size field on its fourth byte
  assign size_word = swap_size_bytes ?
                     {cur.size_accum[7:0], cur.size_accum[15:8],
                      cur.size_accum[23:16], data_byte} :
                     {data_byte, cur.size_accum};
  assign size_end  = {13'd0, used_inc} + {1'b0, size_word};

  // orientation value prefix compare
  always_comb begin
    mask_upd = cur.value_mask;
    for (int i = 0; i < 4; i++) begin
      if (orient_val_char(2'(i), cur.value_pos) != data_byte) mask_upd[i] = 1'b0;
    end
  end

  // per-byte step
  always_comb begin
    st_next                 = cur;
    result.byte_out         = data_byte;
    result.byte_role        = ROLE_IGNORED;
    result.record_ok        = 1'b0;
    result.error_code       = ERR_NONE;
    if (active) begin
      st_next.region_used = used_inc;
      unique case (cur.phase)
        PH_SIZE: begin
          result.byte_role = ROLE_SIZE;
          if (cur.size_cnt != 2'd3) begin
            st_next.size_accum[8*cur.size_cnt +: 8] = data_byte;
            st_next.size_cnt = cur.size_cnt + 2'd1;
            if (used_inc >= region_bytes) begin
              result.error_code = ERR_SIZE_TRUNC;
              st_next.stopped   = 1'b1;
            end
          end else begin
            st_next.size_cnt   = 2'd0;
            st_next.size_accum = 24'd0;
            if (size_end > {13'd0, region_bytes}) begin
              result.error_code = ERR_OVERRUN;
              st_next.stopped   = 1'b1;
            end else if (size_word == 32'd0) begin
              result.error_code = ERR_KEY_NUL;
              st_next.stopped   = 1'b1;
            end else begin
              st_next.record_left   = size_word[19:0];
              st_next.pad_left      = 2'd0 - size_word[1:0];
              st_next.key_pos       = 4'd0;
              st_next.key_is_orient = 1'b1;
              st_next.value_pos     = 3'd0;
              st_next.value_mask    = 4'hF;
              st_next.phase         = PH_KEY;
            end
          end
        end
        PH_KEY: begin
          st_next.record_left = left_dec;
          if (data_byte == 8'h00) begin
            result.byte_role = ROLE_KEY_END;
            if (cur.key_pos != ORIENT_KEY_LEN) st_next.key_is_orient = 1'b0;
            if (left_dec == 20'd0) begin
              result.error_code = ERR_VALUE_NUL;
              st_next.stopped   = 1'b1;
            end else begin
              st_next.phase = PH_VALUE;
            end
          end else begin
            result.byte_role = ROLE_KEY;
            if (cur.key_pos < ORIENT_KEY_LEN &&
                data_byte == orient_key_char(cur.key_pos)) begin
              st_next.key_pos = cur.key_pos + 4'd1;
            end else begin
              st_next.key_is_orient = 1'b0;
            end
            if (left_dec == 20'd0) begin
              result.error_code = ERR_KEY_NUL;
              st_next.stopped   = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          st_next.record_left = left_dec;
          if (data_byte == 8'h00) begin
            result.byte_role = ROLE_VALUE_END;
            if (left_dec != 20'd0) begin
              result.error_code = ERR_VALUE_NUL;
              st_next.stopped   = 1'b1;
            end else begin
              result.record_ok = 1'b1;
              // first orientation record picks the flip bits
              if (cur.key_is_orient && !cur.orient_found) begin
                st_next.orient_found = 1'b1;
                if (cur.value_pos == ORIENT_VAL_LEN) begin
                  priority if (cur.value_mask[0]) st_next.flip_state = 2'd0;
                  else if (cur.value_mask[1])     st_next.flip_state = 2'd1;
                  else if (cur.value_mask[2])     st_next.flip_state = 2'd2;
                  else if (cur.value_mask[3])     st_next.flip_state = 2'd3;
                  else                            st_next.flip_state = cur.flip_state;
                end
              end
              st_next.phase = (cur.pad_left != 2'd0) ? PH_PAD : PH_SIZE;
            end
          end else begin
            result.byte_role = ROLE_VALUE;
            if (cur.value_pos < ORIENT_VAL_LEN) begin
              st_next.value_mask = mask_upd;
              st_next.value_pos  = cur.value_pos + 3'd1;
            end
            if (left_dec == 20'd0) begin
              result.error_code = ERR_VALUE_NUL;
              st_next.stopped   = 1'b1;
            end
          end
        end
        PH_PAD: begin
          result.byte_role = ROLE_PAD;
          st_next.pad_left = cur.pad_left - 2'd1;
          if (cur.pad_left == 2'd1) st_next.phase = PH_SIZE;
        end
        default: st_next = cur;
      endcase
    end
    result.flip_bits        = st_next.flip_state;
    result.orientation_seen = st_next.orient_found;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

endmodule

// ----- hw/rtl/tkvp_skid.sv -----
// ----------------------------------------------------------------------------
// tkvp_skid
// Output register with a skid stage, so the input side can take one further
// beat while a result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module tkvp_skid
  import tkvp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tkvp_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output tkvp_result_t out_data
);

  logic         main_valid;
  logic         skid_valid;
  tkvp_result_t skid_data;
  logic         pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (push) begin
      if (main_valid && !pop) skid_valid <= 1'b1;
      main_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // result beats
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (push) begin
      if (!main_valid || pop) out_data  <= push_data;
      else                    skid_data <= push_data;
    end
  end

endmodule

// ----- hw/rtl/texture_key_value_record_parser.sv -----
// ----------------------------------------------------------------------------
// texture_key_value_record_parser
// Tags each byte of a texture header key/value region with its role,
// checks record framing and picks up the orientation flip bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry data_byte and region_start (high on the first byte of
//   a region). A beat is taken when in_valid is high and in_stall is low.
//   Every input beat yields exactly one result beat on the output channel,
//   taken when out_valid is high and out_stall is low.
//   The result of a taken beat is registered in the output register, or in
//   the skid stage while an earlier result still waits there.
//   Throughput is one beat per cycle while the receiver does not stall; the
//   step is a single compare-and-update pass plus one 33-bit add and compare
//   for the record overrun check.
//   When the receiver stalls, one further beat is caught in a skid stage;
//   in_stall is then high until the receiver takes a beat.
//   Configuration (swap_size_bytes at index 0, region_bytes at index 1) is
//   written through cfg_we/cfg_index/cfg_data, by the user only while idle;
//   the block does not enforce this. Reset clears both registers, the parser
//   and the output stage; region_bytes at zero tags every byte ignored.
// ----------------------------------------------------------------------------
module texture_key_value_record_parser
  import tkvp_pkg::*;
#(
  parameter logic [20:0] MAX_REGION = MAX_REGION_BYTES
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        region_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_out,
  output logic [2:0]  byte_role,
  output logic        record_ok,
  output logic [2:0]  error_code,
  output logic [1:0]  flip_bits,
  output logic        orientation_seen
);

  logic         in_fire;
  tkvp_result_t step_result;
  tkvp_result_t out_data;

  assign in_fire = in_valid && !in_stall;

  // byte step and parser state
  tkvp_core #(
    .MAX_REGION (MAX_REGION)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .data_byte    (data_byte),
    .region_start (region_start),
    .result       (step_result)
  );

  // output register and skid stage
  tkvp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (step_result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign byte_out         = out_data.byte_out;
  assign byte_role        = out_data.byte_role;
  assign record_ok        = out_data.record_ok;
  assign error_code       = out_data.error_code;
  assign flip_bits        = out_data.flip_bits;
  assign orientation_seen = out_data.orientation_seen;

endmodule

// ----- tb/texture_key_value_record_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_key_value_record_parser_tb
// Self-checking bench for the key/value record parser. A short table of
// hand-picked bytes covers disabled regions, size truncation, zero and
// oversized record sizes and a stray value NUL. It is followed by random
// regions built mostly from well-formed records, with orientation keys and
// values, damaged records and noise mixed in. Every result beat is checked
// field by field against a typed tag or the in-bench model of the parser.
// Both the sender and the receiver pause at random.
// ----------------------------------------------------------------------------
module texture_key_value_record_parser_tb;
  import tkvp_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_BYTES = 1500;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE       = 20;

  // orientation key and the four known values, first character in the top byte
  localparam logic [8*14-1:0] ORIENT_KEY_TXT = "KTXorientation";
  localparam logic [4*56-1:0] ORIENT_VAL_TXT = {"S=r,T=d", "S=r,T=u", "S=l,T=d", "S=l,T=u"};

  typedef enum logic [1:0] {SIZE_FIELD, KEY_TEXT, VALUE_TEXT, PAD_BYTES} parse_phase_t;
  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic         swap;
    logic [19:0]  region;
    logic [7:0]   data;
    logic         start;
    logic         typed;
    tkvp_result_t tag;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_SWAP_SIZE_BYTES;
  logic [19:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        region_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  byte_out;
  logic [2:0]  byte_role;
  logic        record_ok;
  logic [2:0]  error_code;
  logic [1:0]  flip_bits;
  logic        orientation_seen;

  texture_key_value_record_parser dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .region_start     (region_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .byte_out         (byte_out),
    .byte_role        (byte_role),
    .record_ok        (record_ok),
    .error_code       (error_code),
    .flip_bits        (flip_bits),
    .orientation_seen (orientation_seen)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // register copies and parser state of the model
  logic         cfg_swap;
  logic [19:0]  cfg_region;
  parse_phase_t cur_phase;
  logic [31:0]  size_shift;
  logic [1:0]   size_count;
  logic [19:0]  bytes_left;
  logic [1:0]   pad_count;
  logic [19:0]  used_count;
  logic [3:0]   key_pos;
  logic         key_match;
  logic [2:0]   val_pos;
  logic [3:0]   val_mask;
  logic         orient_done;
  logic [1:0]   flip_now;
  logic         halted;

  tkvp_result_t expected_tags[$];
  logic [7:0]   region_buf[$];

  int mismatches     = 0;
  int total_bytes    = 0;
  int parsed_count   = 0;
  int good_records   = 0;
  int error_stops    = 0;
  int orient_records = 0;
  int cycle_count    = 0;
  int send_calm      = 0;
  int stall_calm     = 0;

  // directed bytes: typed tags where the answer is obvious, model otherwise
  stim_row_t directed [27] = '{
    // nothing parsed right after reset
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b1, 1'b1, {8'h00, ROLE_IGNORED, 1'b0, ERR_NONE, 2'd1, 1'b0}},
    '{ROW_BYTE, 1'b0, 20'd0, 8'hFF, 1'b0, 1'b1, {8'hFF, ROLE_IGNORED, 1'b0, ERR_NONE, 2'd1, 1'b0}},
    // oversized region is ignored as well
    '{ROW_CFG,  1'b1, 20'hFFFFF, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'hA5, 1'b1, 1'b1, {8'hA5, ROLE_IGNORED, 1'b0, ERR_NONE, 2'd1, 1'b0}},
    // region ends inside the size field
    '{ROW_CFG,  1'b0, 20'd3, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h01, 1'b1, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b0, 1'b1, {8'h00, ROLE_SIZE, 1'b0, ERR_SIZE_TRUNC, 2'd1, 1'b0}},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h7E, 1'b0, 1'b1, {8'h7E, ROLE_IGNORED, 1'b0, ERR_NONE, 2'd1, 1'b0}},
    // largest region: zero-size record, then an all-ones size
    '{ROW_CFG,  1'b1, 20'h80000, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b1, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b0, 1'b1, {8'h00, ROLE_SIZE, 1'b0, ERR_KEY_NUL, 2'd1, 1'b0}},
    '{ROW_BYTE, 1'b0, 20'd0, 8'hFF, 1'b1, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'hFF, 1'b0, 1'b1, {8'hFF, ROLE_SIZE, 1'b0, ERR_OVERRUN, 2'd1, 1'b0}},
    // four-byte record whose value NUL comes one byte early
    '{ROW_CFG,  1'b0, 20'd8, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h04, 1'b1, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h41, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h00, 1'b0, 1'b1, {8'h00, ROLE_VALUE_END, 1'b0, ERR_VALUE_NUL, 2'd1, 1'b0}},
    '{ROW_BYTE, 1'b0, 20'd0, 8'h78, 1'b0, 1'b1, {8'h78, ROLE_IGNORED, 1'b0, ERR_NONE, 2'd1, 1'b0}}
  };

  // parser back to its reset state, registers untouched
  task automatic clear_parse_state();
    cur_phase   = SIZE_FIELD;
    size_shift  = '0;
    size_count  = '0;
    bytes_left  = '0;
    pad_count   = '0;
    used_count  = '0;
    key_pos     = '0;
    key_match   = 1'b1;
    val_pos     = '0;
    val_mask    = 4'hF;
    orient_done = 1'b0;
    flip_now    = 2'd1;
    halted      = 1'b0;
  endtask

  // role, status and orientation of one region byte
  task automatic tag_next_byte(input logic [7:0] b, input logic start,
                               output tkvp_result_t r);
    logic [31:0] sz;
    logic [32:0] reach;
    r = '0;
    r.byte_out   = b;
    r.byte_role  = ROLE_IGNORED;
    r.error_code = ERR_NONE;
    if (start) clear_parse_state();
    if (cfg_region != 0 && {1'b0, cfg_region} <= MAX_REGION_BYTES && !halted &&
        used_count < cfg_region) begin
      used_count++;
      case (cur_phase)
        SIZE_FIELD: begin
          r.byte_role = ROLE_SIZE;
          size_shift[8*size_count +: 8] = b;
          if (size_count != 2'd3) begin
            size_count++;
            if (used_count >= cfg_region) begin
              r.error_code = ERR_SIZE_TRUNC;
              halted = 1'b1;
            end
          end else begin
            sz = cfg_swap ? {size_shift[7:0], size_shift[15:8], size_shift[23:16],
                             size_shift[31:24]} : size_shift;
            size_count = '0;
            size_shift = '0;
            reach = {13'd0, used_count} + {1'b0, sz};
            if (reach > {13'd0, cfg_region}) begin
              r.error_code = ERR_OVERRUN;
              halted = 1'b1;
            end else if (sz == 0) begin
              r.error_code = ERR_KEY_NUL;
              halted = 1'b1;
            end else begin
              bytes_left = sz[19:0];
              pad_count  = 2'd0 - sz[1:0];
              key_pos    = '0;
              key_match  = 1'b1;
              val_pos    = '0;
              val_mask   = 4'hF;
              cur_phase  = KEY_TEXT;
            end
          end
        end
        KEY_TEXT: begin
          bytes_left = bytes_left - 20'd1;
          if (b == 8'h00) begin
            r.byte_role = ROLE_KEY_END;
            if (key_pos != ORIENT_KEY_LEN) key_match = 1'b0;
            if (bytes_left == 0) begin
              r.error_code = ERR_VALUE_NUL;
              halted = 1'b1;
            end else begin
              cur_phase = VALUE_TEXT;
            end
          end else begin
            r.byte_role = ROLE_KEY;
            if (key_pos < ORIENT_KEY_LEN) begin
              if (b == ORIENT_KEY_TXT[8*(13 - int'(key_pos)) +: 8]) key_pos++;
              else key_match = 1'b0;
            end else begin
              key_match = 1'b0;
            end
            if (bytes_left == 0) begin
              r.error_code = ERR_KEY_NUL;
              halted = 1'b1;
            end
          end
        end
        VALUE_TEXT: begin
          bytes_left = bytes_left - 20'd1;
          if (b == 8'h00) begin
            r.byte_role = ROLE_VALUE_END;
            if (bytes_left != 0) begin
              r.error_code = ERR_VALUE_NUL;
              halted = 1'b1;
            end else begin
              r.record_ok = 1'b1;
              if (key_match && !orient_done) begin
                orient_done = 1'b1;
                orient_records++;
                // lowest matching value wins
                if (val_pos >= ORIENT_VAL_LEN)
                  for (int i = 3; i >= 0; i--) if (val_mask[i]) flip_now = 2'(i);
              end
              cur_phase = (pad_count != 0) ? PAD_BYTES : SIZE_FIELD;
            end
          end else begin
            r.byte_role = ROLE_VALUE;
            if (val_pos < ORIENT_VAL_LEN) begin
              for (int i = 0; i < 4; i++)
                if (ORIENT_VAL_TXT[(3 - i)*56 + (6 - int'(val_pos))*8 +: 8] != b)
                  val_mask[i] = 1'b0;
              val_pos++;
            end
            if (bytes_left == 0) begin
              r.error_code = ERR_VALUE_NUL;
              halted = 1'b1;
            end
          end
        end
        default: begin
          r.byte_role = ROLE_PAD;
          pad_count = pad_count - 2'd1;
          if (pad_count == 0) cur_phase = SIZE_FIELD;
        end
      endcase
    end
    r.flip_bits        = flip_now;
    r.orientation_seen = orient_done;
  endtask

  // pause length for one beat, with occasional stretches of back-to-back beats
  task automatic draw_wait(inout int calm, output int n);
    if (calm > 0) begin
      calm--;
      n = 0;
    end else if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(20, 80);
      n = 0;
    end else begin
      n = $urandom_range(0, 15);
    end
  endtask

  // one input beat; the tag is worked out once the beat is taken
  task automatic send_byte(input logic [7:0] b, input logic start, input logic use_typed,
                           input tkvp_result_t typed_tag);
    tkvp_result_t r;
    int gap;
    draw_wait(send_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    region_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tag_next_byte(b, start, r);
    expected_tags.insert(expected_tags.size(), use_typed ? typed_tag : r);
    total_bytes++;
    if (r.byte_role != ROLE_IGNORED) parsed_count++;
    if (r.record_ok) good_records++;
    if (r.error_code != ERR_NONE) error_stops++;
  endtask

  // stop sending and let every tag come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk);
  endtask

  // both registers, one write beat each, only while idle
  task automatic set_config(input logic swap, input logic [19:0] region);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SWAP_SIZE_BYTES;
    cfg_data  <= {19'd0, swap};
    @(posedge clk);
    cfg_swap  = swap;
    cfg_index <= CFG_REGION_BYTES;
    cfg_data  <= region;
    @(posedge clk);
    cfg_region = region;
    cfg_we    <= 1'b0;
  endtask

  // append one record to the region buffer, sometimes damaged
  task automatic add_record(input logic swap);
    logic [7:0]  key_b[$];
    logic [7:0]  val_b[$];
    logic [31:0] sz;
    int pick, flaw, n, which, body, pad;
    pick = $urandom_range(0, 9);
    flaw = $urandom_range(0, 19);
    // key: orientation, near miss of it, or random text
    if (pick < 4) begin
      for (int i = 0; i < 14; i++) key_b.insert(key_b.size(), ORIENT_KEY_TXT[8*(13 - i) +: 8]);
      if (pick == 3) begin
        if ($urandom_range(0, 1)) key_b.delete($urandom_range(0, 13));
        else key_b.insert(key_b.size(), "s");
      end
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) key_b.insert(key_b.size(), 8'($urandom_range(1, 255)));
    end
    // value: a known orientation, possibly short, altered or extended, or random text
    if (pick < 4 && $urandom_range(0, 3) != 0) begin
      which = $urandom_range(0, 3);
      for (int i = 0; i < 7; i++)
        val_b.insert(val_b.size(), ORIENT_VAL_TXT[(3 - which)*56 + (6 - i)*8 +: 8]);
      case ($urandom_range(0, 5))
        0: begin
          n = $urandom_range(0, 6);
          while (val_b.size() > n) void'(val_b.pop_back());
        end
        1: val_b[$urandom_range(0, 6)] = 8'($urandom_range(1, 255));
        2: repeat ($urandom_range(1, 4)) val_b.insert(val_b.size(), 8'($urandom_range(1, 255)));
        default: ;
      endcase
    end else begin
      n = $urandom_range(0, 12);
      repeat (n) val_b.insert(val_b.size(), 8'($urandom_range(1, 255)));
    end
    // stray NUL inside the value, size kept consistent
    if (flaw == 5) val_b.insert($urandom_range(0, val_b.size()), 8'h00);
    body = key_b.size() + val_b.size() + 2;
    sz = body;
    case (flaw)
      0:       sz = '0;
      1:       sz = $urandom;
      2, 3:    sz = $urandom_range(1, body - 1);
      4:       sz = body + $urandom_range(1, 3);
      default: ;
    endcase
    for (int i = 0; i < 4; i++)
      region_buf.insert(region_buf.size(), swap ? sz[8*(3 - i) +: 8] : sz[8*i +: 8]);
    foreach (key_b[i]) region_buf.insert(region_buf.size(), key_b[i]);
    region_buf.insert(region_buf.size(), 8'h00);
    foreach (val_b[i]) region_buf.insert(region_buf.size(), val_b[i]);
    region_buf.insert(region_buf.size(), 8'h00);
    pad = (4 - (body % 4)) % 4;
    repeat (pad) region_buf.insert(region_buf.size(), 8'($urandom_range(0, 255)));
  endtask

  // result beat check against the oldest expected tag
  always @(posedge clk) begin
    tkvp_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tags.size() == 0) begin
        $error("result beat with no tag expected: byte_out %0h", byte_out);
        mismatches++;
      end else begin
        want = expected_tags.pop_front();
        if (byte_out !== want.byte_out) begin
          $error("byte_out: expected %0h, got %0h", want.byte_out, byte_out);
          mismatches++;
        end
        if (byte_role !== want.byte_role) begin
          $error("byte_role: expected %0d, got %0d", want.byte_role, byte_role);
          mismatches++;
        end
        if (record_ok !== want.record_ok) begin
          $error("record_ok: expected %0d, got %0d", want.record_ok, record_ok);
          mismatches++;
        end
        if (error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, error_code);
          mismatches++;
        end
        if (flip_bits !== want.flip_bits) begin
          $error("flip_bits: expected %0d, got %0d", want.flip_bits, flip_bits);
          mismatches++;
        end
        if (orientation_seen !== want.orientation_seen) begin
          $error("orientation_seen: expected %0d, got %0d", want.orientation_seen,
                 orientation_seen);
          mismatches++;
        end
      end
    end
  end

  // receiver: a random stall, sometimes none, ahead of each result beat
  initial begin
    int n;
    @(posedge clk);
    forever begin
      draw_wait(stall_calm, n);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tags outstanding", cycle_count,
               expected_tags.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic        swap;
    logic [19:0] region;
    int          kind, len, n;
    cfg_swap   = 1'b0;
    cfg_region = '0;
    clear_parse_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain();
        set_config(directed[i].swap, directed[i].region);
      end else begin
        send_byte(directed[i].data, directed[i].start, directed[i].typed, directed[i].tag);
      end
    end

    // random regions, mostly well-formed records
    while (total_bytes < RANDOM_BYTES) begin
      region_buf.delete();
      swap = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // noise with region starts sprinkled in
        n = $urandom_range(4, 40);
        region = 20'($urandom_range(1, 48));
        drain();
        set_config(swap, region);
        repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 4)) add_record(swap);
        len = region_buf.size();
        case (kind)
          1:       region = '0;
          2:       region = 20'($urandom_range(524289, 1048575));
          3:       region = MAX_REGION_BYTES[19:0];
          4, 5:    region = 20'($urandom_range(1, len - 1));
          6:       region = 20'(len + $urandom_range(1, 8));
          default: region = 20'(len);
        endcase
        drain();
        set_config(swap, region);
        foreach (region_buf[i]) send_byte(region_buf[i], i == 0, 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d bytes, %0d of them parsed, in %0d cycles", total_bytes, parsed_count,
             cycle_count);
    $display("%0d clean records, %0d parse stops, %0d orientation records, %0d mismatches",
             good_records, error_stops, orient_records, mismatches);
    if (mismatches == 0 && expected_tags.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tkvp_pkg.sv
hw/rtl/tkvp_core.sv
hw/rtl/tkvp_skid.sv
hw/rtl/texture_key_value_record_parser.sv
tb/texture_key_value_record_parser_tb.sv
